@@ rtl/rth_pkg.sv @@
// Package for the RGB to HSV converter: widths, stage payload types and codes.
package rth_pkg;

  localparam int CW  = 8;   // color channel width
  localparam int QW  = 16;  // quotient width, hue and saturation
  localparam int SDW = 8;   // saturation divisor width (max)
  localparam int HDW = 11;  // hue divisor width (6 * delta)
  localparam int NW  = 12;  // signed hue numerator width before wrap

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [CW-1:0] brightness;
    logic [CW-1:0] alpha;
    logic          hue_zero;
    logic          sat_zero;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [SDW-1:0] sat_rem;
    logic [QW-1:0]  sat_low;
    logic [SDW-1:0] sat_div;
    logic [HDW-1:0] hue_rem;
    logic [HDW-1:0] hue_div;
  } front_t;

endpackage

@@ rtl/rth_pix_if.sv @@
// Input channel: one RGBA pixel per beat.
interface rth_pix_if;
  import rth_pkg::*;

  logic          valid;
  logic          ready;
  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;
  logic [CW-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

@@ rtl/rth_hsv_if.sv @@
// Output channel: one HSV pixel plus alpha per beat.
interface rth_hsv_if;
  import rth_pkg::*;

  logic          valid;
  logic          ready;
  logic [QW-1:0] hue;
  logic [QW-1:0] saturation;
  logic [CW-1:0] brightness;
  logic [CW-1:0] alpha_out;

  modport source (output valid, output hue, output saturation, output brightness,
                  output alpha_out, input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                input alpha_out, output ready);
endinterface

@@ rtl/rgb_to_hsv_top.sv @@
// Top level of the RGB to HSV converter: front stages, divide pipeline, output register.
//
//   channel  dir  beat
//   pix      in   red, green, blue, alpha (8 bits each)
//   hsv      out  hue, saturation (16 bits), brightness, alpha_out (8 bits)
//
// One pixel per cycle while hsv is not stalled (2 front stages, 16 divide stages with
// one quotient bit each, output register). The divide pipeline depth sets latency.
// rst is synchronous and clears all valid bits; payload registers are not reset.
// When hsv holds a beat that is not taken, the whole pipeline freezes and
// pix.ready drops in the same cycle; nothing is dropped or repeated.
module rgb_to_hsv_top (
  input  logic        clk,
  input  logic        rst,
  rth_pix_if.sink     pix,
  rth_hsv_if.source   hsv
);
  import rth_pkg::*;

  logic          adv;
  logic          f_valid, d_valid;
  front_t        f_data;
  side_t         d_side;
  logic [QW-1:0] sat_q, hue_q;

  logic          out_vld;
  logic [QW-1:0] out_hue, out_sat;
  logic [CW-1:0] out_bri, out_alpha;

  assign adv       = !out_vld || hsv.ready;
  assign pix.ready = adv;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pix.valid),
    .red       (pix.red),
    .green     (pix.green),
    .blue      (pix.blue),
    .alpha     (pix.alpha),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  rth_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_side  (d_side),
    .sat_q     (sat_q),
    .hue_q     (hue_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hue   <= d_side.hue_zero ? '0 : hue_q;
      out_sat   <= d_side.sat_zero ? '0 : sat_q;
      out_bri   <= d_side.brightness;
      out_alpha <= d_side.alpha;
    end
  end

  assign hsv.valid      = out_vld;
  assign hsv.hue        = out_hue;
  assign hsv.saturation = out_sat;
  assign hsv.brightness = out_bri;
  assign hsv.alpha_out  = out_alpha;

endmodule

@@ rtl/rth_front.sv @@
// Front stages: max/min and sector select, then delta, hue numerator and divide operands.
module rth_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          alpha,
  output logic                out_valid,
  output rth_pkg::front_t     out_data
);
  import rth_pkg::*;

  // stage 1
  logic          v1;
  logic [CW-1:0] r1, g1, b1, a1, mx1, mn1;
  max_sel_t      sel1;

  logic [CW-1:0] mx_c, mn_c;
  max_sel_t      sel_c;

  always_comb begin
    mx_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    if (red >= green && red >= blue) begin
      sel_c = MAX_RED;
    end else if (green >= blue) begin
      sel_c = MAX_GREEN;
    end else begin
      sel_c = MAX_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1   <= red;
      g1   <= green;
      b1   <= blue;
      a1   <= alpha;
      mx1  <= mx_c;
      mn1  <= mn_c;
      sel1 <= sel_c;
    end
  end

  // stage 2
  logic [CW-1:0]        delta;
  logic signed [NW-1:0] d12, r12, g12, b12, six, n_raw, n_wrap;
  logic [CW+QW-1:0]     sat_x;
  front_t               data_c;

  always_comb begin
    delta = mx1 - mn1;
    d12   = signed'({{(NW-CW){1'b0}}, delta});
    r12   = signed'({{(NW-CW){1'b0}}, r1});
    g12   = signed'({{(NW-CW){1'b0}}, g1});
    b12   = signed'({{(NW-CW){1'b0}}, b1});
    six   = (d12 <<< 2) + (d12 <<< 1);
    case (sel1)
      MAX_RED:   n_raw = g12 - b12;
      MAX_GREEN: n_raw = (d12 <<< 1) + b12 - r12;
      MAX_BLUE:  n_raw = (d12 <<< 2) + r12 - g12;
      default:   n_raw = '0;
    endcase
    n_wrap = n_raw[NW-1] ? n_raw + six : n_raw;
    // delta * 65535 = (delta << 16) - delta
    sat_x  = {delta, {QW{1'b0}}} - {{QW{1'b0}}, delta};

    data_c.side.brightness = mx1;
    data_c.side.alpha      = a1;
    data_c.side.hue_zero   = (delta == '0);
    data_c.side.sat_zero   = (mx1 == '0);
    data_c.sat_rem         = sat_x[CW+QW-1:QW];
    data_c.sat_low         = sat_x[QW-1:0];
    data_c.sat_div         = mx1;
    data_c.hue_rem         = n_wrap[HDW-1:0];
    data_c.hue_div         = six[HDW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_c;
    end
  end

endmodule

@@ rtl/rth_div_step.sv @@
// One registered restoring-division step: one quotient bit per stage.
module rth_div_step #(
  parameter int DW = 8
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DW-1:0]          rem_in,
  input  logic [rth_pkg::QW-1:0] low_in,
  input  logic [rth_pkg::QW-1:0] quo_in,
  input  logic [DW-1:0]          div_in,
  output logic [DW-1:0]          rem_out,
  output logic [rth_pkg::QW-1:0] low_out,
  output logic [rth_pkg::QW-1:0] quo_out,
  output logic [DW-1:0]          div_out
);
  import rth_pkg::*;

  logic [DW:0] t, d, diff;
  logic        ge;

  always_comb begin
    t    = {rem_in, low_in[QW-1]};
    d    = {1'b0, div_in};
    ge   = (t >= d);
    diff = t - d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[DW-1:0] : t[DW-1:0];
      low_out <= {low_in[QW-2:0], 1'b0};
      quo_out <= {quo_in[QW-2:0], ge};
      div_out <= div_in;
    end
  end

endmodule

@@ rtl/rth_div_pipe.sv @@
// Divide pipeline: saturation and hue quotients, one bit per stage, with side data.
module rth_div_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  rth_pkg::front_t        in_data,
  output logic                   out_valid,
  output rth_pkg::side_t         out_side,
  output logic [rth_pkg::QW-1:0] sat_q,
  output logic [rth_pkg::QW-1:0] hue_q
);
  import rth_pkg::*;

  logic [SDW-1:0] s_rem [QW+1];
  logic [QW-1:0]  s_low [QW+1];
  logic [QW-1:0]  s_quo [QW+1];
  logic [SDW-1:0] s_div [QW+1];
  logic [HDW-1:0] h_rem [QW+1];
  logic [QW-1:0]  h_low [QW+1];
  logic [QW-1:0]  h_quo [QW+1];
  logic [HDW-1:0] h_div [QW+1];
  logic           vld   [QW+1];
  side_t          side  [QW+1];

  assign s_rem[0] = in_data.sat_rem;
  assign s_low[0] = in_data.sat_low;
  assign s_quo[0] = '0;
  assign s_div[0] = in_data.sat_div;
  assign h_rem[0] = in_data.hue_rem;
  assign h_low[0] = '0;
  assign h_quo[0] = '0;
  assign h_div[0] = in_data.hue_div;
  assign vld[0]   = in_valid;
  assign side[0]  = in_data.side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    rth_div_step #(.DW(SDW)) u_sat (
      .clk     (clk),
      .en      (en),
      .rem_in  (s_rem[i]),
      .low_in  (s_low[i]),
      .quo_in  (s_quo[i]),
      .div_in  (s_div[i]),
      .rem_out (s_rem[i+1]),
      .low_out (s_low[i+1]),
      .quo_out (s_quo[i+1]),
      .div_out (s_div[i+1])
    );

    rth_div_step #(.DW(HDW)) u_hue (
      .clk     (clk),
      .en      (en),
      .rem_in  (h_rem[i]),
      .low_in  (h_low[i]),
      .quo_in  (h_quo[i]),
      .div_in  (h_div[i]),
      .rem_out (h_rem[i+1]),
      .low_out (h_low[i+1]),
      .quo_out (h_quo[i+1]),
      .div_out (h_div[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_side  = side[QW];
  assign sat_q     = s_quo[QW];
  assign hue_q     = h_quo[QW];

  // remainders and shifted-out bits of the last stage are not needed
  logic unused;
  assign unused = ^{s_rem[QW], s_low[QW], s_div[QW], h_rem[QW], h_low[QW], h_div[QW]};

endmodule

@@ rtl/rth_checker.sv @@
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rth_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] hue,
  input logic [15:0] saturation,
  input logic [7:0]  brightness,
  input logic [7:0]  alpha_out
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
      && $stable(brightness) && $stable(alpha_out))
    else $error("output beat changed while stalled");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled output");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && brightness == 8'd0 |-> hue == 16'd0 && saturation == 16'd0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturation == 16'd0 |-> hue == 16'd0)
    else $error("grey pixel with nonzero hue");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  logic unused;
  assign unused = in_valid;

endmodule

bind rgb_to_hsv_top rth_checker u_rth_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix.valid),
  .in_ready   (pix.ready),
  .out_valid  (hsv.valid),
  .out_ready  (hsv.ready),
  .hue        (hsv.hue),
  .saturation (hsv.saturation),
  .brightness (hsv.brightness),
  .alpha_out  (hsv.alpha_out)
);

@@ bench/tb_rgb_to_hsv_top.sv @@
// Testbench for rgb_to_hsv_top: pixel stimulus with random flow control, predicted HSV checks.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_top;
  import rth_pkg::*;

  localparam int RANDOM_PIXELS  = 1880;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [QW-1:0] hue;
    logic [QW-1:0] saturation;
    logic [CW-1:0] brightness;
    logic [CW-1:0] alpha;
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } hsv_expect_t;

  class hsv_scoreboard;
    hsv_expect_t expected_q[$];
    int errors;
    int checked;
    int pixels;
    int greys;

    function new();
      errors  = 0;
      checked = 0;
      pixels  = 0;
      greys   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // exact integer HSV conversion, red > green > blue priority on ties
    function hsv_expect_t convert(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b,
                                  logic [CW-1:0] a);
      int mx, mn, delta, six, num;
      max_sel_t sel;
      hsv_expect_t res;
      mx  = r;
      sel = MAX_RED;
      if (g > mx) begin
        mx  = g;
        sel = MAX_GREEN;
      end
      if (b > mx) begin
        mx  = b;
        sel = MAX_BLUE;
      end
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      res.hue        = '0;
      res.saturation = '0;
      res.brightness = CW'(mx);
      res.alpha      = a;
      res.red        = r;
      res.green      = g;
      res.blue       = b;
      if (mx != 0) res.saturation = QW'((delta * 65535) / mx);
      if (mx != 0 && delta != 0) begin
        six = 6 * delta;
        case (sel)
          MAX_RED:   num = int'(g) - int'(b);
          MAX_GREEN: num = 2 * delta + int'(b) - int'(r);
          default:   num = 4 * delta + int'(r) - int'(g);
        endcase
        if (num < 0) num += six;
        res.hue = QW'((longint'(num) * 65536) / six);
      end
      return res;
    endfunction

    function void note_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b,
                             logic [CW-1:0] a);
      expected_q.push_back(convert(r, g, b, a));
      pixels++;
      if (r == g && g == b) greys++;
    endfunction

    task check_result(input logic [QW-1:0] hue, input logic [QW-1:0] sat,
                      input logic [CW-1:0] bright, input logic [CW-1:0] alpha);
      hsv_expect_t exp_beat;
      string pix_name;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat hue %0d sat %0d val %0d alpha %0d",
                         hue, sat, bright, alpha));
      end else begin
        exp_beat = expected_q.pop_front();
        checked++;
        pix_name = $sformatf("rgb(%0d,%0d,%0d)", exp_beat.red, exp_beat.green, exp_beat.blue);
        if (hue !== exp_beat.hue)
          report($sformatf("%s hue %0d, want %0d", pix_name, hue, exp_beat.hue));
        if (sat !== exp_beat.saturation)
          report($sformatf("%s saturation %0d, want %0d", pix_name, sat, exp_beat.saturation));
        if (bright !== exp_beat.brightness)
          report($sformatf("%s brightness %0d, want %0d", pix_name, bright,
                           exp_beat.brightness));
        if (alpha !== exp_beat.alpha)
          report($sformatf("%s alpha %0d, want %0d", pix_name, alpha, exp_beat.alpha));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   idle_cycles;
  bit   sender_steady;
  int   directed_count;

  hsv_scoreboard sb = new();

  rth_pix_if pix();
  rth_hsv_if hsv();

  rgb_to_hsv_top DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .hsv (hsv)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, occasionally long ones
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                            input logic [CW-1:0] b, input logic [CW-1:0] a);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    pix.alpha <= a;
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(r, g, b, a);
  endtask

  task automatic drain_results();
    pix.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_pixel();
    logic [CW-1:0] ch[3];
    int k;
    k = $urandom_range(0, 99);
    foreach (ch[i]) ch[i] = CW'($urandom);
    if (k < 12) begin
      ch[1] = ch[0];
      ch[2] = ch[0];
      if ($urandom_range(0, 1)) ch[$urandom_range(0, 2)] += CW'($urandom_range(0, 2) - 1);
    end else if (k < 27) begin
      case ($urandom_range(0, 2))
        0: ch[1] = ch[0];
        1: ch[2] = ch[1];
        default: ch[2] = ch[0];
      endcase
    end else if (k < 37) begin
      foreach (ch[i])
        case ($urandom_range(0, 2))
          0: ch[i] = '0;
          1: ch[i] = '1;
          default: ;
        endcase
    end else if (k < 45) begin
      foreach (ch[i]) ch[i] = CW'($urandom_range(0, 3));
    end
    send_pixel(ch[0], ch[1], ch[2], CW'($urandom));
  endtask

  // result side: check accepted beats, random backpressure with calm stretches
  initial begin
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    hsv.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hsv.valid && hsv.ready)
        sb.check_result(hsv.hue, hsv.saturation, hsv.brightness, hsv.alpha_out);
      if (calm > 0) begin
        calm--;
        hsv.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        hsv.ready <= 1'b0;
      end else begin
        hsv.ready <= 1'b1;
        if ($urandom_range(0, 299) == 0) calm = $urandom_range(50, 300);
        else stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (hsv.valid && hsv.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    sender_steady = 1'b0;
    pix.valid     = 1'b0;
    pix.red       = '0;
    pix.green     = '0;
    pix.blue      = '0;
    pix.alpha     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // black, white, greys, primaries, ties, wrap and small deltas
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'h5A);
    send_pixel(8'd1,   8'd1,   8'd1,   8'hA5);
    send_pixel(8'd255, 8'd0,   8'd0,   8'h55);
    send_pixel(8'd0,   8'd255, 8'd0,   8'hAA);
    send_pixel(8'd0,   8'd0,   8'd255, 8'd1);
    send_pixel(8'd255, 8'd255, 8'd0,   8'd254);
    send_pixel(8'd0,   8'd255, 8'd255, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd255, 8'd127);
    send_pixel(8'd255, 8'd0,   8'd1,   8'd0);
    send_pixel(8'd200, 8'd10,  8'd50,  8'd17);
    send_pixel(8'd200, 8'd50,  8'd10,  8'd34);
    send_pixel(8'd10,  8'd200, 8'd50,  8'd68);
    send_pixel(8'd50,  8'd200, 8'd10,  8'd136);
    send_pixel(8'd10,  8'd50,  8'd200, 8'd200);
    send_pixel(8'd50,  8'd10,  8'd200, 8'd99);
    send_pixel(8'd1,   8'd0,   8'd0,   8'd3);
    send_pixel(8'd0,   8'd0,   8'd1,   8'd6);
    send_pixel(8'd0,   8'd1,   8'd0,   8'd12);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd24);
    send_pixel(8'd1,   8'd1,   8'd0,   8'd48);
    send_pixel(8'd254, 8'd255, 8'd255, 8'd96);
    send_pixel(8'd100, 8'd100, 8'd99,  8'd192);
    directed_count = sb.pixels;
    drain_results();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_PIXELS / 2) drain_results();
      random_pixel();
    end
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("converted %0d pixels (%0d directed, %0d grey or black), %0d results checked",
             sb.pixels, directed_count, sb.greys, sb.checked);
    $display("random flow control on both channels, %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rth_pkg.sv
rtl/rth_pix_if.sv
rtl/rth_hsv_if.sv
rtl/rth_front.sv
rtl/rth_div_step.sv
rtl/rth_div_pipe.sv
rtl/rgb_to_hsv_top.sv
rtl/rth_checker.sv
bench/tb_rgb_to_hsv_top.sv
